// ----- rtl/core/dq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // Ring geometry.
  localparam int Depth = 16;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  // Field widths of the stream beats.
  localparam int ValueW      = 32;
  localparam int CountFieldW = 5;
  localparam int InDataW     = 32;
  localparam int InUserW     = 2;
  localparam int OutFieldW   = 3 * ValueW + CountFieldW + 1;
  localparam int OutDataW    = ((OutFieldW + 7) / 8) * 8;
  localparam int OutPadW     = OutDataW - OutFieldW;
  localparam int OutUserW    = 2;

  localparam logic [ValueW-1:0] IntMin = {1'b1, {(ValueW - 1){1'b0}}};

  // Operation codes carried in the input tuser.
  localparam logic OpPush   = 1'b0;
  localparam logic OpPop    = 1'b1;
  // End code: push to the rear, pop from the front.
  localparam logic EndOuter = 1'b1;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [ValueW-1:0] word_t;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StFetch = 3'b010,
    StPost  = 3'b100
  } state_e;

  typedef struct packed {
    logic step;
    logic fetch;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // (base + off) modulo Depth, for base below Depth and off up to Depth.
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [CntW:0] sum;
    sum = (CntW + 1)'(base) + (CntW + 1)'(off);
    if (sum >= (CntW + 1)'(Depth)) begin
      sum = sum - (CntW + 1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_tvalid_i,
  output logic                s_tready_o,
  input  dq_pkg::dp_status_t  status_i,
  output dq_pkg::ctrl_cmd_t   cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    s_tready_o     = (state_q == StIdle);
    cmd_o.step     = (state_q == StIdle) && s_tvalid_i;
    cmd_o.fetch    = (state_q == StFetch);
    cmd_o.load_out = (state_q == StPost) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = StPost;
      end
      StPost: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  dq_pkg::ctrl_cmd_t                   cmd_i,
  output dq_pkg::dp_status_t                  status_o,
  input  wire  [dq_pkg::InDataW-1:0]          s_tdata_i,
  input  wire  [dq_pkg::InUserW-1:0]          s_tuser_i,
  output logic                                m_tvalid_o,
  input  wire                                 m_tready_i,
  output logic [dq_pkg::OutDataW-1:0]         m_tdata_o,
  output logic [dq_pkg::OutUserW-1:0]         m_tuser_o
);
  import dq_pkg::*;

  word_t mem [Depth];
  word_t rdata_q;

  idx_t  head_q, head_d;
  cnt_t  cnt_q, cnt_d;
  word_t front_q, front_d;
  word_t rear_q, rear_d;
  word_t popped_q, popped_d;
  logic  under_q, under_d;
  logic  over_q, over_d;
  logic  fetch_en_q, fetch_en_d;
  logic  fetch_front_q, fetch_front_d;

  logic  mem_we;
  idx_t  mem_waddr;
  idx_t  mem_raddr;

  logic  m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic [OutUserW-1:0] m_user_q, m_user_d;

  logic  op;
  logic  end_code;
  word_t value;
  logic  is_full;
  logic  is_empty;
  word_t front_out;
  word_t rear_out;

  assign op       = s_tuser_i[0];
  assign end_code = s_tuser_i[1];
  assign value    = s_tdata_i[ValueW-1:0];
  assign is_full  = (cnt_q == CntW'(Depth));
  assign is_empty = (cnt_q == '0);

  // Pointer update, ring write and the address of the one neighbor to fetch.
  always_comb begin
    head_d        = head_q;
    cnt_d         = cnt_q;
    front_d       = front_q;
    rear_d        = rear_q;
    popped_d      = popped_q;
    under_d       = under_q;
    over_d        = over_q;
    fetch_en_d    = fetch_en_q;
    fetch_front_d = fetch_front_q;
    mem_we        = 1'b0;
    mem_waddr     = ring_add(head_q, cnt_q);
    mem_raddr     = head_q;

    if (cmd_i.step) begin
      popped_d   = '0;
      under_d    = 1'b0;
      over_d     = 1'b0;
      fetch_en_d = 1'b0;
      if (op == OpPush) begin
        if (is_full) begin
          over_d = 1'b1;
        end else if (end_code == EndOuter) begin
          mem_we = 1'b1;
          rear_d = value;
          if (is_empty) begin
            front_d = value;
          end
          cnt_d = cnt_q + CntW'(1);
        end else begin
          head_d    = ring_add(head_q, CntW'(Depth - 1));
          mem_waddr = head_d;
          mem_we    = 1'b1;
          front_d   = value;
          if (is_empty) begin
            rear_d = value;
          end
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        if (is_empty) begin
          under_d  = 1'b1;
          popped_d = IntMin;
        end else if (end_code == EndOuter) begin
          popped_d      = front_q;
          head_d        = ring_add(head_q, CntW'(1));
          mem_raddr     = head_d;
          cnt_d         = cnt_q - CntW'(1);
          fetch_en_d    = 1'b1;
          fetch_front_d = 1'b1;
        end else begin
          // The new rear sits one slot before the old rear.
          popped_d      = rear_q;
          cnt_d         = cnt_q - CntW'(1);
          mem_raddr     = ring_add(head_q, cnt_q - CntW'(2));
          fetch_en_d    = 1'b1;
          fetch_front_d = 1'b0;
        end
      end
    end

    if (cmd_i.fetch && fetch_en_q) begin
      if (fetch_front_q) begin
        front_d = rdata_q;
      end else begin
        rear_d = rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= value;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Result register toward the output side.
  always_comb begin
    front_out = is_empty ? '0 : front_q;
    rear_out  = is_empty ? '0 : rear_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_valid_d = m_valid_q;
    if (cmd_i.load_out) begin
      m_data_d  = {{OutPadW{1'b0}}, is_empty, CountFieldW'(cnt_q),
                   rear_out, front_out, popped_q};
      m_user_d  = {over_q, under_q};
      m_valid_d = 1'b1;
    end else if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  assign status_o.out_free = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      cnt_q      <= '0;
      fetch_en_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      fetch_en_q <= fetch_en_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q       <= front_d;
    rear_q        <= rear_d;
    popped_q      <= popped_d;
    under_q       <= under_d;
    over_q        <= over_d;
    fetch_front_q <= fetch_front_d;
    m_data_q      <= m_data_d;
    m_user_q      <= m_user_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// s_axis    in         tdata: value; tuser: op, end_code
// m_axis    out        tdata: popped_value, front_value, rear_value, count, empty_res;
//                      tuser: underflow, overflow
//
// Each item passes through accept, then the registered ring read of the new
// front or rear neighbor, then the load of the output register.
// The output register lets the next beat be accepted while a result waits.
// Reset clears the head, the count, the fetch enable and the output valid flag;
// ring entries are never cleared, since unoccupied entries never reach the output.
// A stalled output holds the block in its last step until the result register frees.

module double_ended_queue (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [31:0] value
  input  wire  [dq_pkg::InDataW-1:0]          s_axis_tdata_i,
  // [0] op, [1] end_code
  input  wire  [dq_pkg::InUserW-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // [31:0] popped_value, [63:32] front_value, [95:64] rear_value,
  // [100:96] count, [101] empty_res, [103:102] zero
  output logic [dq_pkg::OutDataW-1:0]         m_axis_tdata_o,
  // [0] underflow, [1] overflow
  output logic [dq_pkg::OutUserW-1:0]         m_axis_tuser_o
);
  import dq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller sequences one beat at a time through accept, fetch and post.
  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the ring, the pointers, the cached ends and the result register.
  dq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- test/dq_checker.sv -----
`timescale 1ns / 1ps

// Watches both stream channels of the deque, keeps a shadow copy of the ring,
// and compares every result beat with the oldest predicted one.
module dq_checker
  import dq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  input  logic [OutUserW-1:0] m_axis_tuser_i,
  output int                  mismatch_cnt_o,
  output int                  pending_cnt_o,
  output int                  result_cnt_o,
  output int                  overflow_cnt_o,
  output int                  underflow_cnt_o
);

  typedef struct packed {
    word_t                  popped;
    logic                   underflow;
    logic                   overflow;
    word_t                  front;
    word_t                  rear;
    logic [CountFieldW-1:0] count;
    logic                   empty;
  } deque_result_t;

  // Output tdata layout, highest field first.
  typedef struct packed {
    logic [OutPadW-1:0]     pad;
    logic                   empty;
    logic [CountFieldW-1:0] count;
    word_t                  rear;
    word_t                  front;
    word_t                  popped;
  } out_beat_t;

  word_t         ring_mem [Depth];
  int            head_ptr;
  int            fill_lvl;
  deque_result_t pending_results[$];
  int            mismatches;
  int            results;
  int            overflows;
  int            underflows;

  // Applies one push or pop to the shadow ring and returns the result it causes.
  function automatic deque_result_t deque_step(logic op, logic end_sel, word_t val);
    deque_result_t r;
    r = '0;
    if (op == OpPush) begin
      if (fill_lvl >= Depth) begin
        r.overflow = 1'b1;
      end else if (end_sel == EndOuter) begin
        ring_mem[(head_ptr + fill_lvl) % Depth] = val;
        fill_lvl++;
      end else begin
        head_ptr = (head_ptr + Depth - 1) % Depth;
        ring_mem[head_ptr] = val;
        fill_lvl++;
      end
    end else begin
      if (fill_lvl == 0) begin
        r.underflow = 1'b1;
        r.popped    = IntMin;
      end else if (end_sel == EndOuter) begin
        r.popped = ring_mem[head_ptr];
        head_ptr = (head_ptr + 1) % Depth;
        fill_lvl--;
      end else begin
        r.popped = ring_mem[(head_ptr + fill_lvl - 1) % Depth];
        fill_lvl--;
      end
    end
    if (fill_lvl != 0) begin
      r.front = ring_mem[head_ptr];
      r.rear  = ring_mem[(head_ptr + fill_lvl - 1) % Depth];
    end
    r.count = CountFieldW'(fill_lvl);
    r.empty = (fill_lvl == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_res;
    out_beat_t     act;
    if (!rst_ni) begin
      foreach (ring_mem[i]) ring_mem[i] = '0;
      head_ptr   = 0;
      fill_lvl   = 0;
      mismatches = 0;
      results    = 0;
      overflows  = 0;
      underflows = 0;
      pending_results.delete();
    end else begin
      // A result beat can never belong to an item accepted on the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results++;
        act = out_beat_t'(m_axis_tdata_i);
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding: tdata 0x%h tuser 0x%h",
                 m_axis_tdata_i, m_axis_tuser_i);
          mismatches++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("popped_value", exp_res.popped, act.popped);
          check_field("underflow", 32'(exp_res.underflow), 32'(m_axis_tuser_i[0]));
          check_field("overflow", 32'(exp_res.overflow), 32'(m_axis_tuser_i[1]));
          check_field("front_value", exp_res.front, act.front);
          check_field("rear_value", exp_res.rear, act.rear);
          check_field("count", 32'(exp_res.count), 32'(act.count));
          check_field("empty_res", 32'(exp_res.empty), 32'(act.empty));
          check_field("tdata padding", 32'(0), 32'(act.pad));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        exp_res = deque_step(s_axis_tuser_i[0], s_axis_tuser_i[1], s_axis_tdata_i);
        if (exp_res.overflow) overflows++;
        if (exp_res.underflow) underflows++;
        pending_results.push_back(exp_res);
      end
    end
    mismatch_cnt_o  <= mismatches;
    pending_cnt_o   <= pending_results.size();
    result_cnt_o    <= results;
    overflow_cnt_o  <= overflows;
    underflow_cnt_o <= underflows;
  end

endmodule

// ----- test/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps

// Top of the deque testbench. It generates the clock and reset, drives push and
// pop beats into the slave channel, throttles the master channel, and prints
// the verdict. All prediction and comparison lives in dq_checker.
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int    TotalItems  = 1150;
  // Cycles without any accepted beat before the run is declared hung. The
  // slowest legal stretch is a receiver stall plus a sender gap plus the
  // accept, fetch and post steps, so this leaves a wide margin.
  localparam int    IdleLimit   = 1000;
  // Cycles to watch for stray beats after the last expected result.
  localparam int    DrainCycles = 12;
  localparam word_t IntMax      = ~IntMin;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [InUserW-1:0]  s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;

  int mismatch_cnt;
  int pending_cnt;
  int result_cnt;
  int overflow_cnt;
  int underflow_cnt;

  // Stimulus bookkeeping for the summary.
  int push_cnt;
  int pop_cnt;
  // When set, the matching side runs back to back with no idle cycles.
  bit tx_burst;
  bit rx_burst;

  double_ended_queue uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  dq_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_cnt_o   (pending_cnt),
    .result_cnt_o    (result_cnt),
    .overflow_cnt_o  (overflow_cnt),
    .underflow_cnt_o (underflow_cnt)
  );

  // 8 ns period.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Values lean toward the corners of the signed range, with plenty of random
  // words so that every data bit toggles both ways.
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return IntMin;
      1:       return IntMax;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Presents one beat after a random number of idle cycles and returns right
  // after the edge on which it was accepted. Inputs only change on falling
  // edges, and tvalid stays high between back-to-back beats.
  task automatic send_beat(logic op, logic end_sel, word_t val);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = val;
    s_axis_tuser_i  = {end_sel, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op == OpPush) push_cnt++;
    else pop_cnt++;
  endtask

  // Result side: before each beat the receiver holds tready low for a random
  // number of cycles, then keeps it high until a beat goes through.
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    rx_burst        = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // Watchdog: counts consecutive cycles in which neither channel moves a beat.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no beat accepted for %0d cycles, %0d results outstanding",
           IdleLimit, pending_cnt);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int mode;
    int run_len;
    int push_pct;
    logic op;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    push_cnt        = 0;
    pop_cnt         = 0;
    tx_burst        = 1'b0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Popping an empty queue from either end must underflow
    // and report the minimum integer; the data value is ignored.
    send_beat(OpPop, EndOuter, 32'h1234_5678);
    send_beat(OpPop, ~EndOuter, '1);
    // Removing the only element, once from each end, must leave the queue empty.
    send_beat(OpPush, EndOuter, IntMin);
    send_beat(OpPop, EndOuter, '0);
    send_beat(OpPush, ~EndOuter, IntMax);
    send_beat(OpPop, ~EndOuter, '1);
    // Fill the ring from alternating ends, first with corner values, so the
    // head wraps below zero, then push once more at each end to hit overflow.
    for (int i = 0; i < Depth; i++) begin
      case (i)
        0:       send_beat(OpPush, 1'(i), '0);
        1:       send_beat(OpPush, 1'(i), '1);
        2:       send_beat(OpPush, 1'(i), IntMin);
        3:       send_beat(OpPush, 1'(i), IntMax);
        default: send_beat(OpPush, 1'(i), (i % 2) ? 32'h5555_5500 + i : 32'hAAAA_AA00 + i);
      endcase
    end
    send_beat(OpPush, EndOuter, 32'hDEAD_BEEF);
    send_beat(OpPush, ~EndOuter, 32'hCAFE_F00D);
    send_beat(OpPop, EndOuter, '0);
    send_beat(OpPop, ~EndOuter, '0);

    // Random part, in runs that lean toward filling, draining or neither, so
    // the queue keeps swinging between full and empty with random contents.
    while (push_cnt + pop_cnt < TotalItems) begin
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(16, 64);
      case (mode)
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (run_len) begin
        op = ($urandom_range(0, 99) < push_pct) ? OpPush : OpPop;
        send_beat(op, 1'($urandom_range(0, 1)), pick_word());
      end
      if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    // Let every outstanding result come out, then watch a little longer for
    // any beat that should not be there.
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drove %0d beats (%0d pushes, %0d pops) and checked %0d results.",
             push_cnt + pop_cnt, push_cnt, pop_cnt, result_cnt);
    $display("Pushes refused on a full queue: %0d; pops from an empty queue: %0d.",
             overflow_cnt, underflow_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
